/* rtl/core/rbsi_pkg.sv */
// Shared types and constants for the ray versus box slab intersection block.
// No dependencies; every other file of the block imports this package.
package rbsi_pkg;

  // Default coordinate width and the fixed direction format (signed Q2.30).
  localparam int COORD_WIDTH_DEF = 32;
  localparam int HEAD_WIDTH      = 32;
  localparam int HEAD_FRAC       = 30;
  localparam int NUM_AXES        = 3;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } reg_idx_t;

  // Status of one axis lane: direction component is zero, origin outside the slab.
  typedef struct packed {
    logic zero_dir;
    logic outside;
  } lane_flags_t;

  // Running interval status while the axes are merged.
  typedef struct packed {
    logic lo_open;
    logic hi_open;
    logic miss;
  } fold_t;

endpackage

/* rtl/core/ray_box_slab_intersection_top.sv */
// Throughput: one ray per cycle while the output is not stalled; each of the three
// axis lanes holds two dividers that resolve one quotient bit per stage, so the
// divider chain sets the latency.
// A stalled output holds its stage while empty stages upstream keep filling.
// Reset (synchronous, rst_n low) empties the pipeline and loads the empty box.
// Top level of the ray versus box slab test; uses rbsi_pkg, rbsi_lane, rbsi_merge.
module ray_box_slab_intersection_top #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int DW          = (COORD_WIDTH > 32) ? 64 : 32,
  parameter int AW          = (COORD_WIDTH > 32) ? 6 : 5
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_WIDTH-1:0]          in_origin_x,
  input  logic signed [COORD_WIDTH-1:0]          in_origin_y,
  input  logic signed [COORD_WIDTH-1:0]          in_origin_z,
  input  logic signed [rbsi_pkg::HEAD_WIDTH-1:0] in_heading_x,
  input  logic signed [rbsi_pkg::HEAD_WIDTH-1:0] in_heading_y,
  input  logic signed [rbsi_pkg::HEAD_WIDTH-1:0] in_heading_z,
  input  logic signed [COORD_WIDTH-1:0]          in_near_limit,
  input  logic signed [COORD_WIDTH-1:0]          in_far_limit,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_hit,
  output logic signed [COORD_WIDTH-1:0]          out_t_enter,
  output logic signed [COORD_WIDTH-1:0]          out_t_exit,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [AW-1:0]                          paddr,
  input  logic [DW-1:0]                          pwdata,
  output logic [DW-1:0]                          prdata,
  output logic                                   pready
);
  import rbsi_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int NST = CW + 3;
  localparam int ASH = AW - 3;
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] box_min_r [NUM_AXES];
  logic signed [CW-1:0] box_max_r [NUM_AXES];
  logic [2:0]           reg_idx;
  logic                 wr_en;

  logic [NST-1:0]       v_r;
  logic [NST:0]         ready;
  logic signed [CW-1:0] near_r [CW+1];
  logic signed [CW-1:0] far_r  [CW+1];

  logic signed [CW-1:0]      origin_c  [NUM_AXES];
  logic signed [HEAD_WIDTH-1:0] heading_c [NUM_AXES];
  logic signed [CW-1:0]      smin_w    [NUM_AXES];
  logic signed [CW-1:0]      smax_w    [NUM_AXES];
  lane_flags_t               flags_w   [NUM_AXES];

  // Configuration port: register writes and read mux.
  assign pready  = 1'b1;
  assign reg_idx = paddr[AW-1:ASH];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_min_r[a] <= MAXV;
        box_max_r[a] <= MINV;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_BOX_MIN_X: box_min_r[0] <= pwdata[CW-1:0];
        REG_BOX_MIN_Y: box_min_r[1] <= pwdata[CW-1:0];
        REG_BOX_MIN_Z: box_min_r[2] <= pwdata[CW-1:0];
        REG_BOX_MAX_X: box_max_r[0] <= pwdata[CW-1:0];
        REG_BOX_MAX_Y: box_max_r[1] <= pwdata[CW-1:0];
        REG_BOX_MAX_Z: box_max_r[2] <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BOX_MIN_X: prdata = DW'(box_min_r[0]);
      REG_BOX_MIN_Y: prdata = DW'(box_min_r[1]);
      REG_BOX_MIN_Z: prdata = DW'(box_min_r[2]);
      REG_BOX_MAX_X: prdata = DW'(box_max_r[0]);
      REG_BOX_MAX_Y: prdata = DW'(box_max_r[1]);
      REG_BOX_MAX_Z: prdata = DW'(box_max_r[2]);
      default:       prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage loads when it is empty or its successor moves.
  always_comb begin
    ready[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      ready[k] = !v_r[k] || ready[k+1];
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ready[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (ready[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Ray limits travel alongside the lanes up to the merging stage.
  always_ff @(posedge clk) begin
    if (ready[0]) begin
      near_r[0] <= in_near_limit;
      far_r[0]  <= in_far_limit;
    end
    for (int k = 1; k <= CW; k++) begin
      if (ready[k]) begin
        near_r[k] <= near_r[k-1];
        far_r[k]  <= far_r[k-1];
      end
    end
  end

  // One lane per axis.
  assign origin_c[0]  = in_origin_x;
  assign origin_c[1]  = in_origin_y;
  assign origin_c[2]  = in_origin_z;
  assign heading_c[0] = in_heading_x;
  assign heading_c[1] = in_heading_y;
  assign heading_c[2] = in_heading_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbsi_lane #(.CW(CW)) u_lane (
      .clk     (clk),
      .en      (ready[CW:0]),
      .origin  (origin_c[a]),
      .heading (heading_c[a]),
      .bmin    (box_min_r[a]),
      .bmax    (box_max_r[a]),
      .smin    (smin_w[a]),
      .smax    (smax_w[a]),
      .flags   (flags_w[a])
    );
  end

  rbsi_merge #(.CW(CW)) u_merge (
    .clk        (clk),
    .en_a       (ready[CW+1]),
    .en_b       (ready[CW+2]),
    .smin       (smin_w),
    .smax       (smax_w),
    .flags      (flags_w),
    .near_limit (near_r[CW]),
    .far_limit  (far_r[CW]),
    .hit        (out_hit),
    .t_enter    (out_t_enter),
    .t_exit     (out_t_exit)
  );

  // A miss carries zero parameters.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_t_enter == '0 && out_t_exit == '0)
    else $error("miss result with nonzero parameters");

  // A free output never backs up the input.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // An accepted transaction occupies the first stage.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted transaction lost at the first stage");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented right after reset");

endmodule

/* rtl/core/rbsi_lane.sv */
// One axis lane: slab entry and exit parameters through two pipelined dividers.
// Depends on rbsi_pkg. One quotient bit is resolved per stage.
module rbsi_lane #(
  parameter int CW = rbsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic [CW:0]                            en,
  input  logic signed [CW-1:0]                   origin,
  input  logic signed [rbsi_pkg::HEAD_WIDTH-1:0] heading,
  input  logic signed [CW-1:0]                   bmin,
  input  logic signed [CW-1:0]                   bmax,
  output logic signed [CW-1:0]                   smin,
  output logic signed [CW-1:0]                   smax,
  output rbsi_pkg::lane_flags_t                  flags
);
  import rbsi_pkg::*;

  localparam int NW = CW + 1 + HEAD_FRAC;
  localparam int QW = CW - 1;
  localparam int HW = HEAD_WIDTH;
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  // Front stage values, divider 0 uses the lower bound, divider 1 the upper.
  logic signed [CW:0] diff_c [2];
  logic [CW:0]        mag_c  [2];
  logic [NW-1:0]      num_c  [2];
  logic               hneg_c;
  logic [HW-1:0]      hm_c;

  // Per stage registers of the divider chain.
  logic [HW-1:0]  rem_r  [2][CW];
  logic [QW-1:0]  low_r  [2][CW];
  logic [QW-1:0]  q_r    [2][CW];
  logic           ovf_r  [2][CW];
  logic           zero_r [2][CW];
  logic           neg_r  [2][CW];
  logic [HW-1:0]  hm_r   [CW];
  logic           hneg_r [CW];
  lane_flags_t    fl_r   [CW];

  logic [HW:0]        trial_c [2][CW-1];
  logic               take_c  [2][CW-1];
  logic signed [CW-1:0] val_c [2];
  logic [CW-1:0]      qs_c    [2];

  // Magnitudes and signs of the two dividends and the divisor.
  always_comb begin
    hneg_c = heading[HW-1];
    hm_c   = hneg_c ? HW'(-heading) : HW'(heading);
    for (int d = 0; d < 2; d++) begin
      diff_c[d] = (d == 0) ? ({bmin[CW-1], bmin} - {origin[CW-1], origin})
                           : ({bmax[CW-1], bmax} - {origin[CW-1], origin});
      mag_c[d]  = diff_c[d][CW] ? (CW+1)'(-diff_c[d]) : (CW+1)'(diff_c[d]);
      num_c[d]  = {mag_c[d], {HEAD_FRAC{1'b0}}};
    end
  end

  // Trial subtraction for each divider stage.
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      for (int k = 1; k < CW; k++) begin
        trial_c[d][k-1] = {rem_r[d][k-1], low_r[d][k-1][QW-1]};
        take_c[d][k-1]  = trial_c[d][k-1] >= {1'b0, hm_r[k-1]};
      end
    end
  end

  // Front stage and the quotient bit stages.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int d = 0; d < 2; d++) begin
        rem_r[d][0]  <= num_c[d][NW-1:CW-1];
        low_r[d][0]  <= num_c[d][QW-1:0];
        q_r[d][0]    <= '0;
        ovf_r[d][0]  <= num_c[d][NW-1:CW-1] >= hm_c;
        zero_r[d][0] <= (mag_c[d] == '0);
        neg_r[d][0]  <= diff_c[d][CW] ^ hneg_c;
      end
      hm_r[0]            <= hm_c;
      hneg_r[0]          <= hneg_c;
      fl_r[0].zero_dir   <= (heading == '0);
      fl_r[0].outside    <= (origin < bmin) || (origin > bmax);
    end
    for (int k = 1; k < CW; k++) begin
      if (en[k]) begin
        for (int d = 0; d < 2; d++) begin
          rem_r[d][k]  <= take_c[d][k-1] ? HW'(trial_c[d][k-1] - {1'b0, hm_r[k-1]})
                                         : HW'(trial_c[d][k-1]);
          low_r[d][k]  <= {low_r[d][k-1][QW-2:0], 1'b0};
          q_r[d][k]    <= {q_r[d][k-1][QW-2:0], take_c[d][k-1]};
          ovf_r[d][k]  <= ovf_r[d][k-1];
          zero_r[d][k] <= zero_r[d][k-1];
          neg_r[d][k]  <= neg_r[d][k-1];
        end
        hm_r[k]   <= hm_r[k-1];
        hneg_r[k] <= hneg_r[k-1];
        fl_r[k]   <= fl_r[k-1];
      end
    end
  end

  // Sign, saturation and the bound swap for a negative direction.
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      qs_c[d] = {1'b0, q_r[d][CW-1]};
      if (zero_r[d][CW-1]) begin
        val_c[d] = '0;
      end else if (ovf_r[d][CW-1]) begin
        val_c[d] = neg_r[d][CW-1] ? MINV : MAXV;
      end else begin
        val_c[d] = neg_r[d][CW-1] ? $signed(-qs_c[d]) : $signed(qs_c[d]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[CW]) begin
      smin  <= hneg_r[CW-1] ? val_c[1] : val_c[0];
      smax  <= hneg_r[CW-1] ? val_c[0] : val_c[1];
      flags <= fl_r[CW-1];
    end
  end

endmodule

/* rtl/core/rbsi_merge.sv */
// Merging stage: intersects the three slab intervals, tests the hit and clamps.
// Depends on rbsi_pkg. Two register stages: x and y, then z and the output.
module rbsi_merge #(
  parameter int CW = rbsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  en_a,
  input  logic                  en_b,
  input  logic signed [CW-1:0]  smin [rbsi_pkg::NUM_AXES],
  input  logic signed [CW-1:0]  smax [rbsi_pkg::NUM_AXES],
  input  rbsi_pkg::lane_flags_t flags [rbsi_pkg::NUM_AXES],
  input  logic signed [CW-1:0]  near_limit,
  input  logic signed [CW-1:0]  far_limit,
  output logic                  hit,
  output logic signed [CW-1:0]  t_enter,
  output logic signed [CW-1:0]  t_exit
);
  import rbsi_pkg::*;

  // Narrows the running interval with one axis.
  function automatic void axis_fold(
    input  fold_t              st_i,
    input  logic signed [CW-1:0] lo_i,
    input  logic signed [CW-1:0] hi_i,
    input  lane_flags_t        lf,
    input  logic signed [CW-1:0] s_lo,
    input  logic signed [CW-1:0] s_hi,
    output fold_t              st_o,
    output logic signed [CW-1:0] lo_o,
    output logic signed [CW-1:0] hi_o
  );
    st_o = st_i;
    lo_o = lo_i;
    hi_o = hi_i;
    if (lf.zero_dir) begin
      if (lf.outside) st_o.miss = 1'b1;
    end else begin
      if ((!st_i.lo_open && lo_i > s_hi) || (!st_i.hi_open && s_lo > hi_i)) begin
        st_o.miss = 1'b1;
      end
      if (st_i.lo_open || s_lo > lo_i) begin
        lo_o = s_lo;
        st_o.lo_open = 1'b0;
      end
      if (st_i.hi_open || s_hi < hi_i) begin
        hi_o = s_hi;
        st_o.hi_open = 1'b0;
      end
    end
  endfunction

  fold_t              st_x_c, st_y_c, st_z_c, st_r;
  logic signed [CW-1:0] lo_x_c, hi_x_c, lo_y_c, hi_y_c, lo_z_c, hi_z_c;
  logic signed [CW-1:0] lo_r, hi_r, zmin_r, zmax_r, near_r, far_r;
  lane_flags_t        zfl_r;
  fold_t              open_c;
  logic               hit_c;

  // First stage: x and y slabs.
  always_comb begin
    open_c = '{lo_open: 1'b1, hi_open: 1'b1, miss: 1'b0};
    axis_fold(open_c, '0, '0, flags[0], smin[0], smax[0], st_x_c, lo_x_c, hi_x_c);
    axis_fold(st_x_c, lo_x_c, hi_x_c, flags[1], smin[1], smax[1], st_y_c, lo_y_c, hi_y_c);
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      st_r   <= st_y_c;
      lo_r   <= lo_y_c;
      hi_r   <= hi_y_c;
      zmin_r <= smin[2];
      zmax_r <= smax[2];
      zfl_r  <= flags[2];
      near_r <= near_limit;
      far_r  <= far_limit;
    end
  end

  // Second stage: z slab, hit test against the limits, clamping.
  always_comb begin
    axis_fold(st_r, lo_r, hi_r, zfl_r, zmin_r, zmax_r, st_z_c, lo_z_c, hi_z_c);
    hit_c = !st_z_c.miss && (st_z_c.lo_open || lo_z_c < far_r)
                         && (st_z_c.hi_open || hi_z_c > near_r);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      hit     <= hit_c;
      t_enter <= !hit_c ? '0 : ((st_z_c.lo_open || lo_z_c < near_r) ? near_r : lo_z_c);
      t_exit  <= !hit_c ? '0 : ((st_z_c.hi_open || hi_z_c > far_r) ? far_r : hi_z_c);
    end
  end

endmodule
